// ----- sv/lprd_pkg.sv -----
`default_nettype none
package lprd_pkg;

    localparam int FIELD_BYTES = 4;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_VERDICT = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_SHORT  = 3'd1,
        ST_MANY   = 3'd2,
        ST_CUTLEN = 3'd3,
        ST_CUTPAY = 3'd4,
        ST_TRAIL  = 3'd5
    } status_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] arg_index;
        logic [31:0] arg_length;
        logic [7:0]  payload_byte;
        logic        arg_end;
        status_t     status;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage
`default_nettype wire

// ----- sv/lprd_parser.sv -----
`default_nettype none
module lprd_parser
    import lprd_pkg::*;
#(
    parameter logic [31:0] MAX_ARGS_RESET = 32'd4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_max_args_we,
    input  wire logic [31:0] cfg_max_args_wdata,
    input  wire logic        in_accept,
    input  wire logic [7:0]  data_byte,
    input  wire logic        frame_last,
    output push_t            push
);

    typedef enum logic [2:0] {
        PH_COUNT = 3'd0,
        PH_LEN   = 3'd1,
        PH_PAY   = 3'd2,
        PH_DONE  = 3'd3,
        PH_ERR   = 3'd4
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  fbc_reg, fbc_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] args_left_reg, args_left_next;
    logic [31:0] payload_left_reg, payload_left_next;
    logic [31:0] cur_arg_reg, cur_arg_next;
    status_t     err_reg, err_next;
    logic [31:0] max_args_reg;

    logic [31:0] field_val;
    logic        field_done;
    logic        prim_valid;
    result_t     prim;
    result_t     verdict;

    always_comb begin
        field_val = shift_reg;
        case (fbc_reg)
            2'd0:    field_val[7:0]   = data_byte;
            2'd1:    field_val[15:8]  = data_byte;
            2'd2:    field_val[23:16] = data_byte;
            2'd3:    field_val[31:24] = data_byte;
            default: field_val = shift_reg;
        endcase
        field_done = (fbc_reg == 2'(FIELD_BYTES - 1));
    end

    always_comb begin
        phase_next        = phase_reg;
        fbc_next          = fbc_reg;
        shift_next        = shift_reg;
        args_left_next    = args_left_reg;
        payload_left_next = payload_left_reg;
        cur_arg_next      = cur_arg_reg;
        err_next          = err_reg;
        prim_valid        = 1'b0;
        prim              = '0;
        verdict           = '0;
        verdict.kind      = KIND_VERDICT;

        case (phase_reg)
            PH_COUNT, PH_LEN: begin
                if (field_done) begin
                    fbc_next   = 2'd0;
                    shift_next = '0;
                end else begin
                    fbc_next   = fbc_reg + 2'd1;
                    shift_next = field_val;
                end
                if (field_done && phase_reg == PH_COUNT) begin
                    if (field_val > max_args_reg) begin
                        err_next   = ST_MANY;
                        phase_next = PH_ERR;
                    end else begin
                        args_left_next = field_val;
                        cur_arg_next   = '0;
                        phase_next     = (field_val != '0) ? PH_LEN : PH_DONE;
                    end
                end else if (field_done) begin
                    prim_valid      = 1'b1;
                    prim.kind       = KIND_HEADER;
                    prim.arg_index  = cur_arg_reg;
                    prim.arg_length = field_val;
                    if (field_val == '0) begin
                        args_left_next = args_left_reg - 32'd1;
                        cur_arg_next   = cur_arg_reg + 32'd1;
                        phase_next     = (args_left_reg != 32'd1) ? PH_LEN : PH_DONE;
                    end else begin
                        payload_left_next = field_val;
                        phase_next        = PH_PAY;
                    end
                end
            end
            PH_PAY: begin
                prim_valid        = 1'b1;
                prim.kind         = KIND_PAYLOAD;
                prim.arg_index    = cur_arg_reg;
                prim.payload_byte = data_byte;
                prim.arg_end      = (payload_left_reg == 32'd1);
                payload_left_next = payload_left_reg - 32'd1;
                if (payload_left_reg == 32'd1) begin
                    args_left_next = args_left_reg - 32'd1;
                    cur_arg_next   = cur_arg_reg + 32'd1;
                    phase_next     = (args_left_reg != 32'd1) ? PH_LEN : PH_DONE;
                end
            end
            PH_DONE: begin
                err_next   = ST_TRAIL;
                phase_next = PH_ERR;
            end
            default: begin
                phase_next = PH_ERR;
            end
        endcase

        case (phase_next)
            PH_COUNT: verdict.status = ST_SHORT;
            PH_LEN:   verdict.status = ST_CUTLEN;
            PH_PAY:   verdict.status = ST_CUTPAY;
            PH_DONE:  verdict.status = ST_OK;
            default:  verdict.status = err_next;
        endcase

        push = '0;
        if (in_accept) begin
            if (prim_valid && frame_last) begin
                push.count  = 2'd2;
                push.first  = prim;
                push.second = verdict;
            end else if (prim_valid) begin
                push.count = 2'd1;
                push.first = prim;
            end else if (frame_last) begin
                push.count = 2'd1;
                push.first = verdict;
            end
        end

        if (frame_last) begin
            phase_next        = PH_COUNT;
            fbc_next          = '0;
            shift_next        = '0;
            args_left_next    = '0;
            payload_left_next = '0;
            cur_arg_next      = '0;
            err_next          = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_COUNT;
            fbc_reg          <= '0;
            shift_reg        <= '0;
            args_left_reg    <= '0;
            payload_left_reg <= '0;
            cur_arg_reg      <= '0;
            err_reg          <= ST_OK;
            max_args_reg     <= MAX_ARGS_RESET;
        end else begin
            if (cfg_max_args_we) begin
                max_args_reg <= cfg_max_args_wdata;
            end
            if (in_accept) begin
                phase_reg        <= phase_next;
                fbc_reg          <= fbc_next;
                shift_reg        <= shift_next;
                args_left_reg    <= args_left_next;
                payload_left_reg <= payload_left_next;
                cur_arg_reg      <= cur_arg_next;
                err_reg          <= err_next;
            end
        end
    end

endmodule
`default_nettype wire

// ----- sv/lprd_result_queue.sv -----
`default_nettype none
module lprd_result_queue
    import lprd_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire push_t push,
    output logic       space,
    output logic       out_valid,
    input  wire logic  out_ready,
    output result_t    out_res
);

    localparam int DEPTH = 3;

    result_t    q_reg [DEPTH];
    result_t    q_next [DEPTH];
    logic [1:0] count_reg, count_next;
    logic       pop;
    logic [1:0] base;

    assign out_valid = (count_reg != 2'd0);
    assign out_res   = q_reg[0];
    assign space     = (count_reg <= 2'd1);
    assign pop       = out_valid && out_ready;
    assign base      = count_reg - {1'b0, pop};

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if (pop && i < DEPTH - 1) begin
                q_next[i] = q_reg[(i < DEPTH - 1) ? i + 1 : i];
            end else begin
                q_next[i] = q_reg[i];
            end
            if (push.count != 2'd0 && base == 2'(i)) begin
                q_next[i] = push.first;
            end
            if (push.count == 2'd2 && base + 2'd1 == 2'(i)) begin
                q_next[i] = push.second;
            end
        end
        count_next = base + push.count;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
        for (int i = 0; i < DEPTH; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

endmodule
`default_nettype wire

// ----- sv/length_prefixed_request_deframer.sv -----
// Request frame deframer.
// Input stream: one frame byte per transaction on s_tdata, s_tlast high on the
// frame's last byte. A frame is a 4-byte little-endian argument count, then per
// argument a 4-byte little-endian length and that many payload bytes.
// Output stream: m_tuser gives the result kind (header, payload byte, verdict),
// m_tlast marks the last payload byte of an argument, m_tdata carries the
// argument index, length, payload byte and verdict status.
// The byte parse is done in the cycle a byte is accepted and its results are
// written to a three-entry result queue, whose head register drives the output.
// One byte is accepted per cycle while the queue has space; a byte that
// produces two results (a header or payload byte together with the verdict)
// takes two queue entries and can hold s_tready low until a result is taken.
// s_tready depends only on the queue fill, so a stalled receiver holds the
// results in the queue and input stops once two results are waiting; bytes
// that produce no result are still accepted until then.
// Reset clears the parse state, empties the queue and sets the argument count
// limit to MAX_ARGS_RESET. The limit is written by cfg_max_args_we; the user
// must write it only while the block is idle, which the block does not enforce.
`default_nettype none
module length_prefixed_request_deframer
    import lprd_pkg::*;
#(
    parameter logic [31:0] MAX_ARGS_RESET = 32'd4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_max_args_we,
    input  wire logic [31:0] cfg_max_args_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // [31:0] arg_index, [63:32] arg_length,
                                        // [71:64] payload_byte, [74:72] status
    output logic [1:0]       m_tuser,   // [1:0] kind
    output logic             m_tlast
);

    push_t   push;
    logic    space;
    logic    in_accept;
    result_t out_res;

    assign s_tready  = space;
    assign in_accept = s_tvalid && space;

    lprd_parser #(
        .MAX_ARGS_RESET(MAX_ARGS_RESET)
    ) u_parser (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_max_args_we   (cfg_max_args_we),
        .cfg_max_args_wdata(cfg_max_args_wdata),
        .in_accept         (in_accept),
        .data_byte         (s_tdata),
        .frame_last        (s_tlast),
        .push              (push)
    );

    lprd_result_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .space    (space),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_res  (out_res)
    );

    assign m_tdata = {5'd0, out_res.status, out_res.payload_byte,
                      out_res.arg_length, out_res.arg_index};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.arg_end;

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import lprd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;

    typedef enum logic [2:0] {
        PARSE_COUNT,
        PARSE_LEN,
        PARSE_PAY,
        PARSE_DONE,
        PARSE_ERR
    } parse_phase_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_max_args_we = 1'b0;
    logic [31:0] cfg_max_args_wdata = 32'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    length_prefixed_request_deframer uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_max_args_we    (cfg_max_args_we),
        .cfg_max_args_wdata (cfg_max_args_wdata),
        .s_tvalid           (s_tvalid),
        .s_tready           (s_tready),
        .s_tdata            (s_tdata),
        .s_tlast            (s_tlast),
        .m_tvalid           (m_tvalid),
        .m_tready           (m_tready),
        .m_tdata            (m_tdata),
        .m_tuser            (m_tuser),
        .m_tlast            (m_tlast)
    );

    // Parser state mirrored by the testbench.
    logic [31:0]  limit_args = 32'd4096;
    parse_phase_t parse_phase = PARSE_COUNT;
    logic [1:0]   field_pos = 2'd0;
    logic [31:0]  field_acc = 32'd0;
    logic [31:0]  args_remaining = 32'd0;
    logic [31:0]  payload_remaining = 32'd0;
    logic [31:0]  arg_number = 32'd0;
    status_t      frame_error = ST_OK;

    result_t     expected_results[$];
    frame_byte_t pending_bytes[$];
    logic [7:0]  frame_buf[$];
    frame_byte_t next_byte;
    result_t     next_expected;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int holds_started = 0;
    int hold_left = 0;
    int cycles = 0;
    int failures = 0;
    int bytes_accepted = 0;
    int results_checked = 0;
    int headers_seen = 0;
    int payload_seen = 0;
    int limit_settings = 1;
    int verdicts_seen[8];

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 0;
    end

    task automatic expect_result(input result_t r);
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic add_byte(input logic [7:0] b);
        frame_buf.insert(frame_buf.size(), b);
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last);
        result_t r;
        logic    field_done;
        status_t verdict;
        field_done = 1'b0;
        if (parse_phase == PARSE_COUNT || parse_phase == PARSE_LEN) begin
            field_acc = field_acc | ({24'd0, b} << (8 * field_pos));
            field_done = (field_pos == 2'd3);
            field_pos = field_pos + 2'd1;
        end
        case (parse_phase)
            PARSE_COUNT: begin
                if (field_done) begin
                    if (field_acc > limit_args) begin
                        frame_error = ST_MANY;
                        parse_phase = PARSE_ERR;
                    end else begin
                        args_remaining = field_acc;
                        arg_number = 32'd0;
                        parse_phase = (field_acc != 0) ? PARSE_LEN : PARSE_DONE;
                    end
                    field_acc = 32'd0;
                end
            end
            PARSE_LEN: begin
                if (field_done) begin
                    r = '0;
                    r.kind = KIND_HEADER;
                    r.arg_index = arg_number;
                    r.arg_length = field_acc;
                    r.status = ST_OK;
                    expect_result(r);
                    if (field_acc == 0) begin
                        args_remaining--;
                        arg_number++;
                        parse_phase = (args_remaining != 0) ? PARSE_LEN : PARSE_DONE;
                    end else begin
                        payload_remaining = field_acc;
                        parse_phase = PARSE_PAY;
                    end
                    field_acc = 32'd0;
                end
            end
            PARSE_PAY: begin
                r = '0;
                r.kind = KIND_PAYLOAD;
                r.arg_index = arg_number;
                r.payload_byte = b;
                r.arg_end = (payload_remaining == 1);
                r.status = ST_OK;
                expect_result(r);
                payload_remaining--;
                if (payload_remaining == 0) begin
                    args_remaining--;
                    arg_number++;
                    parse_phase = (args_remaining != 0) ? PARSE_LEN : PARSE_DONE;
                end
            end
            PARSE_DONE: begin
                frame_error = ST_TRAIL;
                parse_phase = PARSE_ERR;
            end
            default: parse_phase = PARSE_ERR;
        endcase
        if (last) begin
            case (parse_phase)
                PARSE_COUNT: verdict = ST_SHORT;
                PARSE_LEN:   verdict = ST_CUTLEN;
                PARSE_PAY:   verdict = ST_CUTPAY;
                PARSE_DONE:  verdict = ST_OK;
                default:     verdict = frame_error;
            endcase
            r = '0;
            r.kind = KIND_VERDICT;
            r.status = verdict;
            expect_result(r);
            parse_phase = PARSE_COUNT;
            field_pos = 2'd0;
            field_acc = 32'd0;
            args_remaining = 32'd0;
            payload_remaining = 32'd0;
            arg_number = 32'd0;
            frame_error = ST_OK;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                parse_byte(s_tdata, s_tlast);
                bytes_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_byte = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= next_byte.data;
                    s_tlast <= next_byte.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // The receiver owns its hold-off counter.
    always @(posedge aclk) begin
        if (holds_started != hold_requests) begin
            holds_started = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("Result transaction with no expectation: kind %0d, tdata %0h",
                       m_tuser, m_tdata);
                failures++;
            end else begin
                next_expected = expected_results.pop_front();
                check_field("kind", 32'(next_expected.kind), 32'(m_tuser));
                check_field("arg_index", next_expected.arg_index, m_tdata[31:0]);
                check_field("arg_length", next_expected.arg_length, m_tdata[63:32]);
                check_field("payload_byte", 32'(next_expected.payload_byte),
                            32'(m_tdata[71:64]));
                check_field("arg_end", 32'(next_expected.arg_end), 32'(m_tlast));
                check_field("status", 32'(next_expected.status), 32'(m_tdata[74:72]));
                case (next_expected.kind)
                    KIND_HEADER:  headers_seen++;
                    KIND_PAYLOAD: payload_seen++;
                    default:      verdicts_seen[next_expected.status]++;
                endcase
            end
            results_checked++;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycles, expected_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic put_word(input logic [31:0] w);
        for (int i = 0; i < FIELD_BYTES; i++) begin
            add_byte(w[8*i +: 8]);
        end
    endtask

    task automatic emit_frame();
        frame_byte_t fb;
        for (int i = 0; i < frame_buf.size(); i++) begin
            fb.data = frame_buf[i];
            fb.last = (i == frame_buf.size() - 1);
            pending_bytes.insert(pending_bytes.size(), fb);
        end
        frame_buf.delete();
    endtask

    task automatic build_args(input int unsigned nargs, input int unsigned lenmax);
        int unsigned len;
        put_word(nargs);
        for (int unsigned a = 0; a < nargs; a++) begin
            len = ($urandom_range(9) == 0) ? 0 : $urandom_range(lenmax);
            put_word(len);
            repeat (len) add_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic random_frame();
        int unsigned pick;
        int unsigned nargs;
        int unsigned lenmax;
        int unsigned cut;
        logic [31:0] count;
        pick = $urandom_range(99);
        nargs = $urandom_range((limit_args < 4) ? limit_args : 4);
        lenmax = ($urandom_range(9) == 0) ? 24 : 6;
        if (pick < 65) begin
            build_args(nargs, lenmax);
        end else if (pick < 77) begin
            build_args(nargs, lenmax);
            cut = $urandom_range(1, frame_buf.size());
            while (frame_buf.size() > cut) frame_buf.delete(frame_buf.size() - 1);
        end else if (pick < 85) begin
            build_args(nargs, lenmax);
            repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(255)));
        end else if (pick < 92 && limit_args != 32'hFFFF_FFFF) begin
            count = limit_args + 32'd1;
            if ($urandom_range(1))
                count = count + ($urandom % (32'hFFFF_FFFF - limit_args));
            put_word(count);
            repeat ($urandom_range(3)) add_byte(8'($urandom_range(255)));
        end else if (pick < 96 && limit_args != 0) begin
            put_word(32'd1);
            put_word($urandom);
            repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic queue_random_frames(input int nbytes);
        int queued;
        queued = 0;
        while (queued < nbytes) begin
            random_frame();
            queued += frame_buf.size();
            emit_frame();
        end
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_bytes.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (5) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [31:0] value);
        @(posedge aclk);
        cfg_max_args_we <= 1'b1;
        cfg_max_args_wdata <= value;
        @(posedge aclk);
        cfg_max_args_we <= 1'b0;
        limit_args = value;
        limit_settings++;
    endtask

    task automatic run_phase(input logic [31:0] value, input int idle, input int stall,
                             input int nbytes, input bit with_hold);
        write_limit(value);
        send_idle_pct = idle;
        stall_pct = stall;
        queue_random_frames(nbytes);
        if (with_hold) begin
            repeat (20) @(posedge aclk);
            hold_requests++;
        end
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // One byte only, ending inside the count.
        add_byte(8'hFF);
        emit_frame();
        // Count of all ones against the reset limit.
        put_word(32'hFFFF_FFFF);
        add_byte(8'h00);
        emit_frame();
        // Zero-length last argument: header and verdict from the same byte.
        put_word(32'd2);
        put_word(32'd1);
        add_byte(8'h00);
        put_word(32'd0);
        emit_frame();
        // Length announces payload that never comes.
        put_word(32'd1);
        put_word(32'd5);
        emit_frame();
        // Frame ends after a whole argument while another is due.
        put_word(32'd2);
        put_word(32'd1);
        add_byte(8'hAB);
        emit_frame();
        // Zero count followed by a stray byte.
        put_word(32'd0);
        add_byte(8'h77);
        emit_frame();
        wait_drained();

        send_idle_pct = 0;
        stall_pct = 0;
        queue_random_frames(200);
        wait_drained();

        run_phase(32'd0, 45, 0, 150, 1'b0);
        run_phase(32'hFFFF_FFFF, 0, 45, 200, 1'b0);
        run_phase(32'd3, 16, 16, 200, 1'b0);
        run_phase(32'($urandom_range(1, 6)), 0, 0, 250, 1'b1);

        repeat (20) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            failures++;
        end
        $display("Covered %0d frame bytes under %0d argument limits; %0d results checked",
                 bytes_accepted, limit_settings, results_checked);
        $display("(%0d headers, %0d payload bytes), verdicts %s: %0d/%0d/%0d/%0d/%0d/%0d.",
                 headers_seen, payload_seen, "ok/short/many/cutlen/cutpay/trail",
                 verdicts_seen[ST_OK], verdicts_seen[ST_SHORT],
                 verdicts_seen[ST_MANY], verdicts_seen[ST_CUTLEN],
                 verdicts_seen[ST_CUTPAY], verdicts_seen[ST_TRAIL]);
        if (failures == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
